// ===== hw/rtl/cwva_pkg.sv =====
package cwva_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int WEIGHT_W    = 16;
  localparam int ACC_W       = 32;
  localparam int RADDR_W     = 18;
  localparam int CFG_SIDE_W  = 7;
  localparam int CFG_MARGIN_W = 5;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;
  localparam int PROD_W      = SAMPLE_W + WEIGHT_W;

  // read results that may be in flight or waiting at the output
  localparam int OUT_FIFO_DEPTH = 8;
  localparam int OUT_PTR_W      = $clog2(OUT_FIFO_DEPTH);
  localparam int OUT_CNT_W      = $clog2(OUT_FIFO_DEPTH + 1);

  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    REG_WIDTH     = 3'd0,
    REG_HEIGHT    = 3'd1,
    REG_DEPTH     = 3'd2,
    REG_MARGIN    = 3'd3,
    REG_WEIGHT    = 3'd4,
    REG_THRESHOLD = 3'd5
  } cfg_reg_e;

  localparam logic [CFG_SIDE_W-1:0]   RST_SIDE      = 7'd64;
  localparam logic [CFG_MARGIN_W-1:0] RST_MARGIN    = 5'd0;
  localparam logic [WEIGHT_W-1:0]     RST_WEIGHT    = 16'hFFFF;
  localparam logic [SAMPLE_W-1:0]     RST_THRESHOLD = 24'd0;

endpackage

// ===== hw/rtl/cwva_ram.sv =====
module cwva_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first: a read of the address written in the same cycle sees the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cropped_weighted_volume_accumulator_core.sv =====
// channel   direction  handshake                 payload
// in        sink       in_valid_i / in_stall_o   op_i, sample_value_i, read_address_i
// out       source     out_valid_o / out_stall_i entry_value_o
// cfg       sink       apb psel/penable/pready   paddr, pwdata, prdata
//
// one item per cycle unless in_stall_o is high; the store is read at stage 3 and
// written back at stage 4, a write-back to the entry read by the next item is
// forwarded; read results wait in the output queue, and up to 8 reads may be
// outstanding, after which in_stall_o holds until results are taken
// after reset a clearing pass writes zero to all STORE_DEPTH entries, one per
// cycle, with in_stall_o high until the pass ends
module cropped_weighted_volume_accumulator_core #(
  parameter int MAX_SIDE    = 64,
  parameter int STORE_DEPTH = 262144
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               op_i,
  input  logic [cwva_pkg::SAMPLE_W-1:0]      sample_value_i,
  input  logic [cwva_pkg::RADDR_W-1:0]       read_address_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [cwva_pkg::ACC_W-1:0]         entry_value_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cwva_pkg::PADDR_W-1:0]       paddr,
  input  logic [cwva_pkg::PDATA_W-1:0]       pwdata,
  output logic [cwva_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int EW = $clog2(MAX_SIDE + 1);
  localparam int RW = 2 * CW;
  localparam int XW = 3 * CW;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int SW = cwva_pkg::SAMPLE_W;
  localparam int AC = cwva_pkg::ACC_W;
  localparam int MW = cwva_pkg::CFG_MARGIN_W;
  localparam int SDW = cwva_pkg::CFG_SIDE_W;

  // ---------------------------------------------------------------- config
  logic [SDW-1:0] width_q, height_q, depth_q;
  logic [MW-1:0]  margin_q;
  logic [cwva_pkg::WEIGHT_W-1:0] weight_q;
  logic [SW-1:0]  thresh_q;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= cwva_pkg::RST_SIDE;
      height_q <= cwva_pkg::RST_SIDE;
      depth_q  <= cwva_pkg::RST_SIDE;
      margin_q <= cwva_pkg::RST_MARGIN;
      weight_q <= cwva_pkg::RST_WEIGHT;
      thresh_q <= cwva_pkg::RST_THRESHOLD;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        cwva_pkg::REG_WIDTH:     width_q  <= pwdata[SDW-1:0];
        cwva_pkg::REG_HEIGHT:    height_q <= pwdata[SDW-1:0];
        cwva_pkg::REG_DEPTH:     depth_q  <= pwdata[SDW-1:0];
        cwva_pkg::REG_MARGIN:    margin_q <= pwdata[MW-1:0];
        cwva_pkg::REG_WEIGHT:    weight_q <= pwdata[cwva_pkg::WEIGHT_W-1:0];
        cwva_pkg::REG_THRESHOLD: thresh_q <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      cwva_pkg::REG_WIDTH:     prdata = 32'(width_q);
      cwva_pkg::REG_HEIGHT:    prdata = 32'(height_q);
      cwva_pkg::REG_DEPTH:     prdata = 32'(depth_q);
      cwva_pkg::REG_MARGIN:    prdata = 32'(margin_q);
      cwva_pkg::REG_WEIGHT:    prdata = 32'(weight_q);
      cwva_pkg::REG_THRESHOLD: prdata = 32'(thresh_q);
      default:                 prdata = '0;
    endcase
  end

  function automatic logic [EW-1:0] eff_side(input logic [SDW-1:0] v);
    logic [EW-1:0] r;
    if (v == '0) begin
      r = EW'(1);
    end else if (32'(v) > 32'(MAX_SIDE)) begin
      r = EW'(MAX_SIDE);
    end else begin
      r = EW'(v);
    end
    return r;
  endfunction

  function automatic logic in_crop(input logic [CW-1:0] pos, input logic [EW-1:0] side,
                                   input logic [MW-1:0] m);
    return (32'(pos) >= 32'(m)) && ((32'(pos) + 32'(m)) < 32'(side));
  endfunction

  // ---------------------------------------------------------------- clear pass
  logic          clr_active_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(STORE_DEPTH - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- stage 0
  localparam int OUT_CNT_W_L = cwva_pkg::OUT_CNT_W;
  logic [OUT_CNT_W_L-1:0] rd_cnt_q;
  logic in_acc, out_acc, in_read;
  logic [EW-1:0] w_eff, h_eff, d_eff;
  logic [CW-1:0] col_q, row_q, pln_q;
  logic keep0;

  assign in_stall_o = clr_active_q | (rd_cnt_q == OUT_CNT_W_L'(cwva_pkg::OUT_FIFO_DEPTH));
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_acc    = out_valid_o & ~out_stall_i;
  assign in_read    = in_acc & (op_i == cwva_pkg::OP_READ);

  assign w_eff = eff_side(width_q);
  assign h_eff = eff_side(height_q);
  assign d_eff = eff_side(depth_q);
  assign keep0 = in_crop(col_q, w_eff, margin_q) && in_crop(row_q, h_eff, margin_q) &&
                 in_crop(pln_q, d_eff, margin_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      pln_q    <= '0;
      rd_cnt_q <= '0;
    end else begin
      if (in_acc && (op_i == cwva_pkg::OP_ACCUM)) begin
        if ((EW'(col_q) + EW'(1)) >= w_eff) begin
          col_q <= '0;
          if ((EW'(row_q) + EW'(1)) >= h_eff) begin
            row_q <= '0;
            if ((EW'(pln_q) + EW'(1)) >= d_eff) begin
              pln_q <= '0;
            end else begin
              pln_q <= pln_q + CW'(1);
            end
          end else begin
            row_q <= row_q + CW'(1);
          end
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      case ({in_read, out_acc})
        2'b10:   rd_cnt_q <= rd_cnt_q + OUT_CNT_W_L'(1);
        2'b01:   rd_cnt_q <= rd_cnt_q - OUT_CNT_W_L'(1);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- pipeline
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic s1_read_q, s2_read_q, s3_read_q, s4_read_q;
  logic s1_add_q, s2_add_q;
  logic s3_wr_q, s4_wr_q;
  logic s3_inr_q, s4_inr_q;
  logic [cwva_pkg::RADDR_W-1:0] s1_raddr_q, s2_raddr_q;
  logic [SW-1:0] s1_sample_q;
  logic [CW-1:0] s1_xoff_q, s1_yoff_q, s1_zoff_q, s2_xoff_q;
  logic [EW-1:0] s1_cw_q, s1_ch_q, s2_cw_q;
  logic [RW-1:0] s2_zrow_q;
  logic [SW-1:0] s2_prod_q, s3_prod_q, s4_prod_q;
  logic [cwva_pkg::PROD_W-1:0] prod_full;
  logic [XW-1:0] caddr;
  logic [AW-1:0] s3_addr_q, s4_addr_q;
  logic          s4_fwd_q;
  logic [AC-1:0] s4_fwd_data_q;
  logic [AC-1:0] ram_rdata, old_val, sum_sat;
  logic [AC:0]   sum_wide;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AC-1:0] ram_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  assign prod_full = cwva_pkg::PROD_W'(s1_sample_q) * cwva_pkg::PROD_W'(weight_q);
  assign caddr     = XW'(s2_zrow_q) * XW'(s2_cw_q) + XW'(s2_xoff_q);

  always_ff @(posedge clk_i) begin
    // stage 1: crop offsets and cropped plane sizes
    s1_read_q   <= (op_i == cwva_pkg::OP_READ);
    s1_add_q    <= (op_i == cwva_pkg::OP_ACCUM) && keep0 && (sample_value_i > thresh_q);
    s1_raddr_q  <= read_address_i;
    s1_sample_q <= sample_value_i;
    s1_xoff_q   <= col_q - CW'(margin_q);
    s1_yoff_q   <= row_q - CW'(margin_q);
    s1_zoff_q   <= pln_q - CW'(margin_q);
    s1_cw_q     <= w_eff - EW'({margin_q, 1'b0});
    s1_ch_q     <= h_eff - EW'({margin_q, 1'b0});
    // stage 2: plane row index and weighted sample
    s2_read_q  <= s1_read_q;
    s2_add_q   <= s1_add_q;
    s2_raddr_q <= s1_raddr_q;
    s2_xoff_q  <= s1_xoff_q;
    s2_cw_q    <= s1_cw_q;
    s2_zrow_q  <= RW'(RW'(s1_zoff_q) * RW'(s1_ch_q)) + RW'(s1_yoff_q);
    s2_prod_q  <= prod_full[cwva_pkg::PROD_W-1:cwva_pkg::WEIGHT_W];
    // stage 3: store address
    s3_read_q <= s2_read_q;
    s3_prod_q <= s2_prod_q;
    s3_inr_q  <= 32'(s2_raddr_q) < 32'(STORE_DEPTH);
    s3_wr_q   <= s2_add_q && (32'(caddr) < 32'(STORE_DEPTH));
    s3_addr_q <= s2_read_q ? AW'(s2_raddr_q) : AW'(caddr);
    // stage 4: store word arrives; catch a write-back to the same entry
    s4_read_q     <= s3_read_q;
    s4_wr_q       <= s3_wr_q;
    s4_inr_q      <= s3_inr_q;
    s4_addr_q     <= s3_addr_q;
    s4_prod_q     <= s3_prod_q;
    s4_fwd_q      <= s4_valid_q && s4_wr_q && (s4_addr_q == s3_addr_q);
    s4_fwd_data_q <= sum_sat;
  end

  assign old_val  = s4_fwd_q ? s4_fwd_data_q : ram_rdata;
  assign sum_wide = {1'b0, old_val} + (AC + 1)'(s4_prod_q);
  assign sum_sat  = sum_wide[AC] ? '1 : sum_wide[AC-1:0];

  assign ram_we    = clr_active_q | (s4_valid_q & s4_wr_q);
  assign ram_waddr = clr_active_q ? clr_addr_q : s4_addr_q;
  assign ram_wdata = clr_active_q ? '0 : sum_sat;

  cwva_ram #(
    .WIDTH (AC),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (s3_valid_q),
    .raddr_i (s3_addr_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- output queue
  logic [AC-1:0] ofifo_q [cwva_pkg::OUT_FIFO_DEPTH];
  logic [cwva_pkg::OUT_PTR_W-1:0] wp_q, rp_q;
  logic [OUT_CNT_W_L-1:0] ocnt_q;
  logic push;

  assign push = s4_valid_q & s4_read_q;

  always_ff @(posedge clk_i) begin
    if (push) begin
      ofifo_q[wp_q] <= s4_inr_q ? old_val : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      ocnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= wp_q + cwva_pkg::OUT_PTR_W'(1);
      end
      if (out_acc) begin
        rp_q <= rp_q + cwva_pkg::OUT_PTR_W'(1);
      end
      case ({push, out_acc})
        2'b10:   ocnt_q <= ocnt_q + OUT_CNT_W_L'(1);
        2'b01:   ocnt_q <= ocnt_q - OUT_CNT_W_L'(1);
        default: ;
      endcase
    end
  end

  assign out_valid_o   = (ocnt_q != '0);
  assign entry_value_o = ofifo_q[rp_q];

endmodule

// ===== hw/rtl/cwva_checker.sv =====
module cwva_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          op_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [cwva_pkg::ACC_W-1:0]    entry_value_o
);

  logic       in_rd, out_beat;
  logic [7:0] pend_q;

  assign in_rd    = in_valid_i & ~in_stall_o & (op_i == cwva_pkg::OP_READ);
  assign out_beat = out_valid_o & ~out_stall_i;

  // reads seen at the ports and not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 8'(in_rd) - 8'(out_beat);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(entry_value_o))
    else $error("stalled result beat dropped or changed");

  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 8'd0)
    else $error("result beat without a pending read");

  a_read_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_rd |-> pend_q < 8'(cwva_pkg::OUT_FIFO_DEPTH))
    else $error("read accepted beyond output queue capacity");

  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> in_stall_o)
    else $error("input taken before store clear");

endmodule

bind cropped_weighted_volume_accumulator_core cwva_checker u_cwva_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .op_i          (op_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .entry_value_o (entry_value_o)
);

// ===== tb/sv/cropped_weighted_volume_accumulator_core_tb.sv =====
module cropped_weighted_volume_accumulator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SIDE      = 64;
  localparam int STORE_DEPTH   = 262144;
  localparam int SETTLE_CYCLES = 12;
  localparam int END_CYCLES    = 20;
  localparam int LIMIT_NS      = 2000000;

  typedef struct {
    bit [cwva_pkg::CFG_SIDE_W-1:0]   side_x;
    bit [cwva_pkg::CFG_SIDE_W-1:0]   side_y;
    bit [cwva_pkg::CFG_SIDE_W-1:0]   side_z;
    bit [cwva_pkg::CFG_MARGIN_W-1:0] margin;
    bit [cwva_pkg::WEIGHT_W-1:0]     weight;
    bit [cwva_pkg::SAMPLE_W-1:0]     threshold;
    int                              beats;
    int                              read_pct;
    int                              max_pct;
  } setting_t;

  class accum_scoreboard;
    bit [cwva_pkg::CFG_SIDE_W-1:0]   width_r;
    bit [cwva_pkg::CFG_SIDE_W-1:0]   height_r;
    bit [cwva_pkg::CFG_SIDE_W-1:0]   depth_r;
    bit [cwva_pkg::CFG_MARGIN_W-1:0] margin_r;
    bit [cwva_pkg::WEIGHT_W-1:0]     weight_r;
    bit [cwva_pkg::SAMPLE_W-1:0]     threshold_r;
    bit [5:0]                        col_cnt;
    bit [5:0]                        row_cnt;
    bit [5:0]                        plane_cnt;
    bit [cwva_pkg::RADDR_W-1:0]      target_addr;
    bit [cwva_pkg::ACC_W-1:0]        acc_mem [int unsigned];
    bit [cwva_pkg::ACC_W-1:0]        pending_entries [$];
    int unsigned                     failures;

    function new();
      width_r     = cwva_pkg::RST_SIDE;
      height_r    = cwva_pkg::RST_SIDE;
      depth_r     = cwva_pkg::RST_SIDE;
      margin_r    = cwva_pkg::RST_MARGIN;
      weight_r    = cwva_pkg::RST_WEIGHT;
      threshold_r = cwva_pkg::RST_THRESHOLD;
    endfunction

    function int unsigned clamp_side(bit [cwva_pkg::CFG_SIDE_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_SIDE) return MAX_SIDE;
      return v;
    endfunction

    function bit in_window(int unsigned pos, int unsigned side);
      return pos >= margin_r && pos + margin_r < side;
    endfunction

    // number of entries the cropped volume covers, zero when nothing is kept
    function int unsigned kept_entries();
      int unsigned w, h, d, m;
      w = clamp_side(width_r);
      h = clamp_side(height_r);
      d = clamp_side(depth_r);
      m = margin_r;
      if (2 * m >= w || 2 * m >= h || 2 * m >= d) return 0;
      return (w - 2 * m) * (h - 2 * m) * (d - 2 * m);
    endfunction

    function void write_reg(cwva_pkg::cfg_reg_e idx, bit [cwva_pkg::PDATA_W-1:0] val);
      case (idx)
        cwva_pkg::REG_WIDTH:     width_r = val[cwva_pkg::CFG_SIDE_W-1:0];
        cwva_pkg::REG_HEIGHT:    height_r = val[cwva_pkg::CFG_SIDE_W-1:0];
        cwva_pkg::REG_DEPTH:     depth_r = val[cwva_pkg::CFG_SIDE_W-1:0];
        cwva_pkg::REG_MARGIN:    margin_r = val[cwva_pkg::CFG_MARGIN_W-1:0];
        cwva_pkg::REG_WEIGHT:    weight_r = val[cwva_pkg::WEIGHT_W-1:0];
        cwva_pkg::REG_THRESHOLD: threshold_r = val[cwva_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_item_beat(cwva_pkg::op_e op, bit [cwva_pkg::SAMPLE_W-1:0] value,
                                 bit [cwva_pkg::RADDR_W-1:0] raddr);
      int unsigned w, h, d, m, addr;
      bit [cwva_pkg::PROD_W-1:0] prod;
      bit [cwva_pkg::ACC_W:0]    sum;
      bit [cwva_pkg::ACC_W-1:0]  entry;
      if (op == cwva_pkg::OP_READ) begin
        if (raddr < STORE_DEPTH && acc_mem.exists(raddr))
          entry = acc_mem[raddr];
        else
          entry = '0;
        pending_entries.insert(pending_entries.size(), entry);
        return;
      end
      w = clamp_side(width_r);
      h = clamp_side(height_r);
      d = clamp_side(depth_r);
      m = margin_r;
      if (in_window(col_cnt, w) && in_window(row_cnt, h) && in_window(plane_cnt, d)) begin
        addr = ((plane_cnt - m) * (h - 2 * m) + (row_cnt - m)) * (w - 2 * m) + (col_cnt - m);
        target_addr = addr[cwva_pkg::RADDR_W-1:0];
        if (value > threshold_r && addr < STORE_DEPTH) begin
          prod = value * weight_r;
          sum = (acc_mem.exists(addr) ? acc_mem[addr] : '0) + prod[cwva_pkg::PROD_W-1:16];
          acc_mem[addr] = sum[cwva_pkg::ACC_W] ? '1 : sum[cwva_pkg::ACC_W-1:0];
        end
      end
      // counters left beyond a shrunk dimension wrap on this advance
      if (col_cnt + 1 >= w) begin
        col_cnt = '0;
        if (row_cnt + 1 >= h) begin
          row_cnt = '0;
          if (plane_cnt + 1 >= d) plane_cnt = '0;
          else plane_cnt = plane_cnt + 6'd1;
        end else begin
          row_cnt = row_cnt + 6'd1;
        end
      end else begin
        col_cnt = col_cnt + 6'd1;
      end
    endfunction

    function void check_entry(logic [cwva_pkg::ACC_W-1:0] got);
      bit [cwva_pkg::ACC_W-1:0] want;
      if (pending_entries.size() == 0) begin
        failures++;
        if (failures <= 10) $display("entry_value %h arrived with no read waiting", got);
        return;
      end
      want = pending_entries.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10) $display("entry_value mismatch: expected %h, got %h", want, got);
      end
    endfunction

    function int unsigned pending();
      return pending_entries.size();
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic                            op_i = cwva_pkg::OP_ACCUM;
  logic [cwva_pkg::SAMPLE_W-1:0]   sample_value_i = '0;
  logic [cwva_pkg::RADDR_W-1:0]    read_address_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [cwva_pkg::ACC_W-1:0]      entry_value_o;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [cwva_pkg::PADDR_W-1:0]    paddr = '0;
  logic [cwva_pkg::PDATA_W-1:0]    pwdata = '0;
  logic [cwva_pkg::PDATA_W-1:0]    prdata;
  logic                            pready;

  accum_scoreboard sb = new();
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  setting_t plan [9];

  cropped_weighted_volume_accumulator_core #(
    .MAX_SIDE   (MAX_SIDE),
    .STORE_DEPTH(STORE_DEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .sample_value_i(sample_value_i),
    .read_address_i(read_address_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .entry_value_o (entry_value_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i == 1'b0) sb.check_entry(entry_value_o);
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #LIMIT_NS;
    $display("FAIL cropped_weighted_volume_accumulator_core");
    $finish;
  end

  task automatic send_item(cwva_pkg::op_e op, logic [cwva_pkg::SAMPLE_W-1:0] value,
                           logic [cwva_pkg::RADDR_W-1:0] raddr);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    sample_value_i <= value;
    read_address_i <= raddr;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.take_item_beat(op, value, raddr);
  endtask

  // accumulates give no result, so let the pipeline empty out after the last read
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(cwva_pkg::cfg_reg_e idx, logic [cwva_pkg::PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(setting_t s);
    settle();
    apb_write(cwva_pkg::REG_WIDTH, 32'(s.side_x));
    apb_write(cwva_pkg::REG_HEIGHT, 32'(s.side_y));
    apb_write(cwva_pkg::REG_DEPTH, 32'(s.side_z));
    apb_write(cwva_pkg::REG_MARGIN, 32'(s.margin));
    apb_write(cwva_pkg::REG_WEIGHT, 32'(s.weight));
    apb_write(cwva_pkg::REG_THRESHOLD, 32'(s.threshold));
  endtask

  task automatic run_random(setting_t s);
    cwva_pkg::op_e                 op;
    logic [cwva_pkg::SAMPLE_W-1:0] value;
    logic [cwva_pkg::RADDR_W-1:0]  raddr;
    int                            r, t;
    int unsigned                   kept;
    for (int i = 0; i < s.beats; i++) begin
      if ($urandom_range(99) < s.read_pct) op = cwva_pkg::OP_READ;
      else op = cwva_pkg::OP_ACCUM;
      r = $urandom_range(99);
      if (r < s.max_pct) begin
        value = '1;
      end else if (r < s.max_pct + 8) begin
        value = '0;
      end else if (r < s.max_pct + 20) begin
        // hug the threshold from both sides
        t = int'(s.threshold) + int'($urandom_range(4)) - 2;
        if (t < 0) t = 0;
        if (t > 24'hFFFFFF) t = 24'hFFFFFF;
        value = t[cwva_pkg::SAMPLE_W-1:0];
      end else begin
        value = cwva_pkg::SAMPLE_W'($urandom());
      end
      kept = sb.kept_entries();
      r = $urandom_range(99);
      if (kept > 0 && r < 75) raddr = cwva_pkg::RADDR_W'($urandom_range(kept - 1));
      else if (r < 85) raddr = cwva_pkg::RADDR_W'($urandom_range(7));
      else raddr = cwva_pkg::RADDR_W'($urandom());
      send_item(op, value, raddr);
    end
  endtask

  initial begin
    setting_t tiny_set, tight_set;
    tiny_set  = '{7'd3, 7'd2, 7'd2, 5'd0, 16'h8000, 24'h000100, 0, 0, 0};
    tight_set = '{7'd3, 7'd2, 7'd2, 5'd1, 16'h8000, 24'h000100, 0, 0, 0};
    plan[0] = '{7'd4, 7'd3, 7'd2, 5'd0, 16'h8000, 24'h400000, 200, 25, 10};
    plan[1] = '{7'd0, 7'd0, 7'd0, 5'd0, 16'hFFFF, 24'h000000, 400, 10, 70};
    plan[2] = '{7'd127, 7'd2, 7'd1, 5'd0, 16'h1234, 24'hFFFFFF, 150, 30, 20};
    plan[3] = '{7'd64, 7'd64, 7'd64, 5'd31, 16'h0000, 24'h000010, 80, 30, 10};
    plan[4] = '{7'd5, 7'd5, 7'd5, 5'd3, 16'hABCD, 24'h000100, 100, 30, 10};
    plan[5] = '{7'd7, 7'd6, 7'd5, 5'd1, 16'h5A5A, 24'h0000FF, 350, 25, 10};
    plan[6] = '{7'd1, 7'd64, 7'd3, 5'd0, 16'h0001, 24'h000000, 150, 25, 10};
    plan[7] = '{7'd64, 7'd64, 7'd64, 5'd0, 16'hFFFF, 24'h000000, 200, 25, 10};
    plan[8] = '{7'd9, 7'd9, 7'd9, 5'd2, 16'hC000, 24'h800000, 175, 25, 10};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: full volume, no crop, weight all ones, threshold zero
    send_item(cwva_pkg::OP_ACCUM, 24'h000000, 18'h00000);
    send_item(cwva_pkg::OP_ACCUM, 24'hFFFFFF, 18'h00000);
    send_item(cwva_pkg::OP_ACCUM, 24'h000001, 18'h3FFFF);
    send_item(cwva_pkg::OP_READ, 24'h000000, 18'h00000);
    send_item(cwva_pkg::OP_READ, 24'h000000, 18'h00001);
    send_item(cwva_pkg::OP_READ, 24'hFFFFFF, 18'h00002);
    send_item(cwva_pkg::OP_READ, 24'h000000, 18'h3FFFF);
    send_item(cwva_pkg::OP_ACCUM, 24'h800000, 18'h00000);
    send_item(cwva_pkg::OP_READ, 24'h000000, 18'h00003);

    // column counter is now past the new width
    apply_setting(tiny_set);
    send_item(cwva_pkg::OP_ACCUM, 24'h000101, 18'h00000);
    send_item(cwva_pkg::OP_ACCUM, 24'h000100, 18'h00000);
    send_item(cwva_pkg::OP_ACCUM, 24'h000101, 18'h00000);
    send_item(cwva_pkg::OP_ACCUM, 24'hFFFFFF, 18'h00000);
    send_item(cwva_pkg::OP_READ, 24'h000000, 18'h00003);
    send_item(cwva_pkg::OP_READ, 24'h000000, 18'h00004);
    send_item(cwva_pkg::OP_READ, 24'h000000, 18'h00005);

    // margin swallows the whole height
    apply_setting(tight_set);
    send_item(cwva_pkg::OP_ACCUM, 24'hFFFFFF, 18'h00000);
    send_item(cwva_pkg::OP_ACCUM, 24'hFFFFFF, 18'h00000);
    send_item(cwva_pkg::OP_READ, 24'h000000, 18'h00005);

    for (int i = 0; i < 9; i++) begin
      apply_setting(plan[i]);
      case (i % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      run_random(plan[i]);
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (END_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("PASS cropped_weighted_volume_accumulator_core");
    else
      $display("FAIL cropped_weighted_volume_accumulator_core");
    $finish;
  end

endmodule
